// File: rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants for the threshold bucket search block.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int CMD_W    = 1;
  localparam int SLOT_W   = 10;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int BUCKET_W = 10;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = COUNT_W'(1);

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

endpackage

// File: rtl/tbs_table.sv
// ----------------------------------------------------------------------------
// tbs_table
// Threshold store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbs_table #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [tbs_pkg::VALUE_W-1:0]  wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [tbs_pkg::VALUE_W-1:0]  rdata
);
  import tbs_pkg::*;

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tbs_search.sv
// ----------------------------------------------------------------------------
// tbs_search
// Command decode, entry count register and the lower-bound search sequencer.
// One probe per cycle: the compare on the returned entry picks the next
// midpoint, whose read is issued in the same cycle.
// ----------------------------------------------------------------------------
module tbs_search #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbs_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [tbs_pkg::CMD_W-1:0]     cmd,
  input  logic [tbs_pkg::SLOT_W-1:0]    slot,
  input  logic [tbs_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [tbs_pkg::BUCKET_W-1:0]  bucket_index,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [tbs_pkg::VALUE_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [tbs_pkg::VALUE_W-1:0]   mem_rdata
);
  import tbs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] entry_count;
  logic [VALUE_W-1:0] score;
  logic [CNT_W-1:0]   left;
  logic [CNT_W-1:0]   right_end;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   hit;

  logic [CNT_W-1:0]   used;
  logic [31:0]        count_wide;
  logic [31:0]        slot_wide;
  logic [31:0]        hit_wide;
  logic               accept;
  logic               accept_query;
  logic               ge;
  logic [CNT_W-1:0]   left_step;
  logic [CNT_W-1:0]   right_step;
  logic [CNT_W-1:0]   hit_step;
  logic               more;
  logic [CNT_W-1:0]   mid_first;
  logic [CNT_W-1:0]   mid_step;

  // floor((l + r - 1) / 2), result only used when r > l
  function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] l,
                                               input logic [CNT_W-1:0] r);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(l) + (CNT_W+1)'(r) - (CNT_W+1)'(1);
    return sum[CNT_W:1];
  endfunction

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign accept_query = accept && (cmd == CMD_QUERY);

  // entries in use: the entry count clamped to the table depth
  assign count_wide = 32'(entry_count);
  assign used       = (count_wide > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(count_wide);

  assign slot_wide = 32'(slot);
  assign mem_we    = accept && (cmd == CMD_WRITE) && (slot_wide < 32'(TABLE_DEPTH));
  assign mem_waddr = slot_wide[ADDR_W-1:0];
  assign mem_wdata = value;

  assign ge         = (mem_rdata >= score);
  assign left_step  = ge ? left : mid + CNT_W'(1);
  assign right_step = ge ? mid : right_end;
  assign hit_step   = ge ? mid : hit;
  assign more       = (left_step < right_step);
  assign mid_first  = mid_of('0, used);
  assign mid_step   = mid_of(left_step, right_step);

  assign mem_re    = (state == ST_IDLE) ? (accept_query && (used != '0)) : more;
  assign mem_raddr = (state == ST_IDLE) ? mid_first[ADDR_W-1:0] : mid_step[ADDR_W-1:0];

  assign hit_wide = 32'(hit_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= ENTRY_COUNT_RESET;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_query) begin
            score     <= value;
            left      <= '0;
            right_end <= used;
            hit       <= '0;
            mid       <= mid_first;
            if (used == '0) begin
              done         <= 1'b1;
              bucket_index <= '0;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          left      <= left_step;
          right_end <= right_step;
          hit       <= hit_step;
          mid       <= mid_step;
          if (!more) begin
            state        <= ST_IDLE;
            done         <= 1'b1;
            bucket_index <= hit_wide[BUCKET_W-1:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/threshold_bucket_search_top.sv
// ----------------------------------------------------------------------------
// threshold_bucket_search_top
// Lower-bound search over a table of ascending thresholds; gives 0 if no threshold is at or above the value.
// ----------------------------------------------------------------------------
// A write item (cmd 0) stores value at slot in the cycle it is taken and
// gives no result; a write can be taken every cycle while busy is low. A query item (cmd 1)
// holds busy while it probes the table, one probe per cycle, since the
// compare on each returned entry sets the address of the next read from
// the store's one read port. With n entries in use a query takes at most
// ceil(log2(n+1)) probes; done pulses for one cycle with bucket_index in
// the cycle after the last probe, and busy is already low then, so the next
// item can be taken while done is high.
// done cannot be held off; take bucket_index when it is high. Slots never
// written must not be probed.
// ----------------------------------------------------------------------------
module threshold_bucket_search_top #(
  parameter int TABLE_DEPTH = tbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbs_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [tbs_pkg::CMD_W-1:0]     cmd,
  input  logic [tbs_pkg::SLOT_W-1:0]    slot,
  input  logic [tbs_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [tbs_pkg::BUCKET_W-1:0]  bucket_index
);
  import tbs_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  tbs_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot         (slot),
    .value        (value),
    .done         (done),
    .bucket_index (bucket_index),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  tbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/tbs_checker.sv
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks on the command handshake and result timing.
// ----------------------------------------------------------------------------
module tbs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [tbs_pkg::CMD_W-1:0] cmd,
  input logic                      done
);
  import tbs_pkg::*;

  // a result always lands with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a write item never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_WRITE)) |=> !done)
    else $error("result after a write item");

  // a query item either finishes at once or starts searching
  a_query_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == CMD_QUERY)) |=> (busy || done))
    else $error("query item dropped");

  // busy only ends with a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without a result");

endmodule

bind threshold_bucket_search_top tbs_checker u_tbs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done)
);
